@@ hdl/pcfj_pkg.sv @@
// Shared constants for the penalty contact force and Jacobian unit.
`default_nettype none

package pcfj_pkg;

	localparam int CFG_W     = 31;          // activation distance and penalty gain
	localparam int DIM_W     = 2;           // dimension register
	localparam int IDX_W     = 2;           // configuration register index
	localparam int PROD_W    = 2 * CFG_W;   // penalty * gap, penalty * activation
	localparam int NUM_AXES  = 3;
	localparam int NUM_PROD  = 6;           // xx yy zz xy xz yz
	localparam int MUL_CHUNK = 32;          // largest multiplier slice

	localparam logic [IDX_W-1:0] REG_DIMENSION = 2'd0;
	localparam logic [IDX_W-1:0] REG_ACT_DIST  = 2'd1;
	localparam logic [IDX_W-1:0] REG_PENALTY   = 2'd2;

	localparam logic [DIM_W-1:0] DIM_RESET = 2'd3;
	localparam logic [CFG_W-1:0] ACT_RESET = 31'd65536;
	localparam logic [CFG_W-1:0] PEN_RESET = 31'd65536;

endpackage

`default_nettype wire

@@ hdl/pcfj_dly.sv @@
// Enabled delay line for side data that travels alongside the arithmetic.
`default_nettype none

module pcfj_dly #(
	parameter int DW = 8,
	parameter int N  = 2
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] d,
	output logic [DW-1:0] q
);

	logic [DW-1:0] sr_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int k = 1; k < N; k++) begin
				sr_q[k] <= sr_q[k-1];
			end
		end
	end

	assign q = sr_q[N-1];

endmodule

`default_nettype wire

@@ hdl/pcfj_mul.sv @@
// Two-stage unsigned multiplier built from 32x32 slices.
`default_nettype none

module pcfj_mul
	import pcfj_pkg::*;
#(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic [AW+BW-1:0] p
);

	localparam int AN = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int BN = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int FW = (AN + BN) * MUL_CHUNK;
	localparam int PPW = 2 * MUL_CHUNK;

	logic [AN*MUL_CHUNK-1:0] a_x;
	logic [BN*MUL_CHUNK-1:0] b_x;
	logic [PPW-1:0]          pp_s1 [AN*BN];
	logic [FW-1:0]           sum_c;
	logic [AW+BW-1:0]        p_s2;

	assign a_x = (AN*MUL_CHUNK)'(a);
	assign b_x = (BN*MUL_CHUNK)'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < AN; i++) begin
				for (int j = 0; j < BN; j++) begin
					pp_s1[i*BN+j] <= PPW'(a_x[i*MUL_CHUNK +: MUL_CHUNK])
						* PPW'(b_x[j*MUL_CHUNK +: MUL_CHUNK]);
				end
			end
		end
	end

	// at most four partial products for the widths used here
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < AN; i++) begin
			for (int j = 0; j < BN; j++) begin
				sum_c = sum_c + (FW'(pp_s1[i*BN+j]) << (MUL_CHUNK * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= sum_c[AW+BW-1:0];
		end
	end

	assign p = p_s2;

endmodule

`default_nettype wire

@@ hdl/pcfj_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module pcfj_sqrt #(
	parameter int RW = 32
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*RW-1:0] rad,
	output logic [RW-1:0]   root
);

	logic [RW+1:0]   rem_s  [RW-1];
	logic [2*RW-1:0] rad_s  [RW-1];
	logic [RW-1:0]   root_s [RW];

	genvar k;
	for (k = 0; k < RW; k++) begin : g_stage
		logic [RW+1:0]   rem_i;
		logic [2*RW-1:0] rad_i;
		logic [RW-1:0]   root_i;
		logic [RW+1:0]   t;
		logic [RW+1:0]   trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign rad_i  = rad;
			assign root_i = '0;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign rad_i  = rad_s[k-1];
			assign root_i = root_s[k-1];
		end

		// remainder stays below 2^RW before the shift
		assign t     = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
		assign trial = {root_i, 2'b01};
		assign ge    = (t >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= {root_i[RW-2:0], ge};
			end
		end

		if (k < RW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? (t - trial) : t;
					rad_s[k] <= {rad_i[2*RW-3:0], 2'b00};
				end
			end
		end
	end

	assign root = root_s[RW-1];

endmodule

`default_nettype wire

@@ hdl/pcfj_div.sv @@
// Pipelined restoring divider, one quotient bit per stage; needs n < d * 2^QW.
`default_nettype none

module pcfj_div #(
	parameter int NW = 64,
	parameter int DW = 32,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] n,
	input  logic [DW-1:0] d,
	output logic [QW-1:0] q
);

	logic [DW+QW-1:0] n_x;
	logic [DW-1:0]    rem_s [QW-1];
	logic [DW-1:0]    dv_s  [QW-1];
	logic [QW-1:0]    nq_s  [QW];

	assign n_x = (DW+QW)'(n);

	genvar k;
	for (k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_i;
		logic [DW-1:0] dv_i;
		logic [QW-1:0] nq_i;
		logic [DW:0]   t;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_i = n_x[DW+QW-1:QW];
			assign dv_i  = d;
			assign nq_i  = n_x[QW-1:0];
		end else begin : g_next
			assign rem_i = rem_s[k-1];
			assign dv_i  = dv_s[k-1];
			assign nq_i  = nq_s[k-1];
		end

		// low numerator bits shift out at the top, quotient bits in at the bottom
		assign t    = {rem_i, nq_i[QW-1]};
		assign diff = t - {1'b0, dv_i};
		assign ge   = (t >= {1'b0, dv_i});

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k] <= {nq_i[QW-2:0], ge};
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
					dv_s[k]  <= dv_i;
				end
			end
		end
	end

	assign q = nq_s[QW-1];

endmodule

`default_nettype wire

@@ hdl/penalty_contact_force_jacobian_unit.sv @@
// Top level of the penalty contact force and Jacobian unit.
// Takes one signed fixed-point separation vector per beat and returns one result beat per
// input: the active flag, the three force components and the six unique entries of the
// symmetric contact Jacobian, each saturated to WORD_WIDTH bits. The unit is a single
// pipeline with valid bits and a common stall: it accepts one beat every cycle unless a
// result is held at the output. Most of the pipeline is the WORD_WIDTH-stage square root
// that forms the distance and the 62-stage dividers behind it. The configuration port is
// always ready; write the registers only while no beat is in flight.
`default_nettype none

module penalty_contact_force_jacobian_unit
	import pcfj_pkg::*;
#(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [IDX_W-1:0]             cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [WORD_WIDTH-1:0] sep_x,
	input  logic signed [WORD_WIDTH-1:0] sep_y,
	input  logic signed [WORD_WIDTH-1:0] sep_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         active,
	output logic signed [WORD_WIDTH-1:0] force_x,
	output logic signed [WORD_WIDTH-1:0] force_y,
	output logic signed [WORD_WIDTH-1:0] force_z,
	output logic signed [WORD_WIDTH-1:0] jac_xx,
	output logic signed [WORD_WIDTH-1:0] jac_yy,
	output logic signed [WORD_WIDTH-1:0] jac_zz,
	output logic signed [WORD_WIDTH-1:0] jac_xy,
	output logic signed [WORD_WIDTH-1:0] jac_xz,
	output logic signed [WORD_WIDTH-1:0] jac_yz
);

	localparam int W    = WORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int QW   = PROD_W;
	localparam int XW   = PROD_W + 2;
	localparam int CMPW = (W > CFG_W) ? W : CFG_W;
	localparam int T0   = W + 5;            // stage of the distance register
	localparam int L    = T0 + 5 + QW;      // stage of the output register

	localparam logic signed [XW-1:0] SAT_HI = $signed((XW'(1) << (W - 1)) - XW'(1));
	localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

	// configuration
	logic [DIM_W-1:0] dim_q;
	logic [CFG_W-1:0] act_q;
	logic [CFG_W-1:0] pen_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
			act_q <= ACT_RESET;
			pen_q <= PEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DIMENSION: dim_q <= cfg_data[DIM_W-1:0];
				REG_ACT_DIST:  act_q <= cfg_data;
				REG_PENALTY:   pen_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits and common stall
	logic [L:1] vld_s;
	logic       adv;

	assign adv      = ~vld_s[L] | out_ready;
	assign in_ready = adv | ~vld_s[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (in_ready) begin
				vld_s[1] <= in_valid;
			end
			if (adv) begin
				for (int k = 2; k <= L; k++) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// stage 1: magnitudes and signs, unused axes forced to zero
	logic [W-1:0]                     sep_u [NUM_AXES];
	logic [NUM_AXES-1:0][W-1:0]       mag_s1;
	logic [NUM_AXES-1:0]              neg_s1;

	assign sep_u[0] = sep_x;
	assign sep_u[1] = sep_y;
	assign sep_u[2] = sep_z;

	always_ff @(posedge clk) begin
		if (in_ready) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				if (DIM_W'(i) < dim_q) begin
					mag_s1[i] <= sep_u[i][W-1] ? ('0 - sep_u[i]) : sep_u[i];
					neg_s1[i] <= sep_u[i][W-1];
				end else begin
					mag_s1[i] <= '0;
					neg_s1[i] <= 1'b0;
				end
			end
		end
	end

	// squares and cross products of the magnitudes
	logic [NUM_PROD-1:0][2*W-1:0] mm_c;

	genvar g;
	for (g = 0; g < NUM_AXES; g++) begin : g_sq
		pcfj_mul #(.AW(W), .BW(W)) u_sq (
			.clk(clk), .en(adv), .a(mag_s1[g]), .b(mag_s1[g]), .p(mm_c[g])
		);
	end

	pcfj_mul #(.AW(W), .BW(W)) u_xy (
		.clk(clk), .en(adv), .a(mag_s1[0]), .b(mag_s1[1]), .p(mm_c[3])
	);
	pcfj_mul #(.AW(W), .BW(W)) u_xz (
		.clk(clk), .en(adv), .a(mag_s1[0]), .b(mag_s1[2]), .p(mm_c[4])
	);
	pcfj_mul #(.AW(W), .BW(W)) u_yz (
		.clk(clk), .en(adv), .a(mag_s1[1]), .b(mag_s1[2]), .p(mm_c[5])
	);

	// stage 2: sum of squares
	logic [2*W+1:0] sumsq_c;
	logic [2*W-1:0] sumsq_s2;

	assign sumsq_c = (2*W+2)'(mm_c[0]) + (2*W+2)'(mm_c[1]) + (2*W+2)'(mm_c[2]);

	always_ff @(posedge clk) begin
		if (adv) begin
			sumsq_s2 <= sumsq_c[2*W-1:0];
		end
	end

	logic [W-1:0] root_c;

	pcfj_sqrt #(.RW(W)) u_sqrt (
		.clk(clk), .en(adv), .rad(sumsq_s2), .root(root_c)
	);

	// stage 3: distance with one-LSB floor, activation test and gap
	logic [W-1:0]    dfl_c;
	logic [CMPW-1:0] gap_c;
	logic [W-1:0]    d_s3;
	logic            act_s3;
	logic [CFG_W-1:0] gap_s3;

	assign dfl_c = (root_c == '0) ? W'(1) : root_c;
	assign gap_c = CMPW'(act_q) - CMPW'(dfl_c);

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3   <= dfl_c;
			act_s3 <= (CMPW'(dfl_c) < CMPW'(act_q));
			gap_s3 <= gap_c[CFG_W-1:0];
		end
	end

	// penalty products and d^2
	logic [PROD_W-1:0] pg_c;
	logic [PROD_W-1:0] pk_c;
	logic [2*W-1:0]    dsq_c;

	pcfj_mul #(.AW(CFG_W), .BW(CFG_W)) u_pg (
		.clk(clk), .en(adv), .a(pen_q), .b(gap_s3), .p(pg_c)
	);
	pcfj_mul #(.AW(CFG_W), .BW(CFG_W)) u_pk (
		.clk(clk), .en(adv), .a(pen_q), .b(act_q), .p(pk_c)
	);
	pcfj_mul #(.AW(W), .BW(W)) u_dsq (
		.clk(clk), .en(adv), .a(d_s3), .b(d_s3), .p(dsq_c)
	);

	// side data aligned to the arithmetic
	logic [NUM_AXES-1:0][W-1:0]   magd_c;
	logic [NUM_PROD-1:0][2*W-1:0] mmd_c;
	logic [NUM_AXES-1:0]          neg_d;
	logic                         act_d;
	logic [W-1:0]                 d_d2;
	logic [W-1:0]                 d_d4;
	logic [PROD_W-1:0]            pg_d2;

	pcfj_dly #(.DW(NUM_AXES*W), .N(T0 + 1)) u_dly_mag (
		.clk(clk), .en(adv), .d(mag_s1), .q(magd_c)
	);
	pcfj_dly #(.DW(NUM_PROD*2*W), .N(T0 - 1)) u_dly_mm (
		.clk(clk), .en(adv), .d(mm_c), .q(mmd_c)
	);
	pcfj_dly #(.DW(NUM_AXES), .N(T0 + 3 + QW)) u_dly_neg (
		.clk(clk), .en(adv), .d(neg_s1), .q(neg_d)
	);
	pcfj_dly #(.DW(1), .N(4 + QW)) u_dly_act (
		.clk(clk), .en(adv), .d(act_s3), .q(act_d)
	);
	pcfj_dly #(.DW(W), .N(2)) u_dly_d2 (
		.clk(clk), .en(adv), .d(d_s3), .q(d_d2)
	);
	pcfj_dly #(.DW(W), .N(2)) u_dly_d4 (
		.clk(clk), .en(adv), .d(d_d2), .q(d_d4)
	);
	pcfj_dly #(.DW(PROD_W), .N(2)) u_dly_pg (
		.clk(clk), .en(adv), .d(pg_c), .q(pg_d2)
	);

	// numerators and d^3
	logic [PROD_W+W-1:0]   numf_c [NUM_AXES];
	logic [PROD_W+2*W-1:0] numm_c [NUM_PROD];
	logic [3*W-1:0]        d3_c;

	for (g = 0; g < NUM_AXES; g++) begin : g_numf
		pcfj_mul #(.AW(PROD_W), .BW(W)) u_mul (
			.clk(clk), .en(adv), .a(pg_c), .b(magd_c[g]), .p(numf_c[g])
		);
	end

	for (g = 0; g < NUM_PROD; g++) begin : g_numm
		pcfj_mul #(.AW(PROD_W), .BW(2*W)) u_mul (
			.clk(clk), .en(adv), .a(pk_c), .b(mmd_c[g]), .p(numm_c[g])
		);
	end

	pcfj_mul #(.AW(2*W), .BW(W)) u_d3 (
		.clk(clk), .en(adv), .a(dsq_c), .b(d_d2), .p(d3_c)
	);

	// dividers; every quotient stays below 2^62
	logic [QW-1:0] qf [NUM_AXES];
	logic [QW-1:0] qm [NUM_PROD];
	logic [QW-1:0] qa;

	for (g = 0; g < NUM_AXES; g++) begin : g_divf
		pcfj_div #(.NW(PROD_W+W), .DW(W+F), .QW(QW)) u_div (
			.clk(clk), .en(adv), .n(numf_c[g]), .d({d_d4, {F{1'b0}}}), .q(qf[g])
		);
	end

	for (g = 0; g < NUM_PROD; g++) begin : g_divm
		pcfj_div #(.NW(PROD_W+2*W), .DW(3*W), .QW(QW)) u_div (
			.clk(clk), .en(adv), .n(numm_c[g]), .d(d3_c), .q(qm[g])
		);
	end

	pcfj_div #(.NW(PROD_W), .DW(W), .QW(QW)) u_diva (
		.clk(clk), .en(adv), .n(pg_d2), .d(d_d4), .q(qa)
	);

	// signing, diagonal difference, saturation
	function automatic logic [W-1:0] sat_word(input logic signed [XW-1:0] v);
		if (v > SAT_HI) begin
			return SAT_HI[W-1:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[W-1:0];
		end
		return v[W-1:0];
	endfunction

	function automatic logic signed [XW-1:0] off_val(input logic [QW-1:0] q,
			input logic ni, input logic nj);
		logic signed [XW-1:0] m;
		m = $signed(XW'(q));
		return (ni != nj) ? m : -m;
	endfunction

	logic signed [XW-1:0] fv [NUM_AXES];
	logic signed [XW-1:0] dv [NUM_AXES];
	logic signed [XW-1:0] ov [NUM_AXES];
	logic [W-1:0]         force_n [NUM_AXES];
	logic [W-1:0]         jac_n   [NUM_PROD];

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			fv[i] = neg_d[i] ? -$signed(XW'(qf[i])) : $signed(XW'(qf[i]));
			dv[i] = $signed(XW'(qa)) - $signed(XW'(qm[i]));
		end
		ov[0] = off_val(qm[3], neg_d[0], neg_d[1]);
		ov[1] = off_val(qm[4], neg_d[0], neg_d[2]);
		ov[2] = off_val(qm[5], neg_d[1], neg_d[2]);

		for (int i = 0; i < NUM_AXES; i++) begin
			force_n[i] = act_d ? sat_word(fv[i]) : '0;
			jac_n[i]   = (act_d && (DIM_W'(i) < dim_q)) ? sat_word(dv[i]) : '0;
		end
		// off-diagonal entry is live when its higher axis is in use
		jac_n[3] = (act_d && (DIM_W'(1) < dim_q)) ? sat_word(ov[0]) : '0;
		jac_n[4] = (act_d && (DIM_W'(2) < dim_q)) ? sat_word(ov[1]) : '0;
		jac_n[5] = (act_d && (DIM_W'(2) < dim_q)) ? sat_word(ov[2]) : '0;
	end

	// stage 4: output register
	logic         act_s4;
	logic [W-1:0] force_s4 [NUM_AXES];
	logic [W-1:0] jac_s4   [NUM_PROD];

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s4   <= act_d;
			force_s4 <= force_n;
			jac_s4   <= jac_n;
		end
	end

	assign out_valid = vld_s[L];
	assign active    = act_s4;
	assign force_x   = $signed(force_s4[0]);
	assign force_y   = $signed(force_s4[1]);
	assign force_z   = $signed(force_s4[2]);
	assign jac_xx    = $signed(jac_s4[0]);
	assign jac_yy    = $signed(jac_s4[1]);
	assign jac_zz    = $signed(jac_s4[2]);
	assign jac_xy    = $signed(jac_s4[3]);
	assign jac_xz    = $signed(jac_s4[4]);
	assign jac_yz    = $signed(jac_s4[5]);

	// checks
	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !active) |-> (force_x == '0 && force_y == '0 && force_z == '0
		&& jac_xx == '0 && jac_yy == '0 && jac_zz == '0
		&& jac_xy == '0 && jac_xz == '0 && jac_yz == '0))
		else $error("inactive result carries nonzero values");

	a_unused_axis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dim_q < DIM_RESET) |-> (jac_zz == '0 && jac_xz == '0
		&& jac_yz == '0 && force_z == '0))
		else $error("unused axis produced a nonzero entry");

	a_head_free: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[1] |-> in_ready)
		else $error("input refused with an empty first stage");

endmodule

`default_nettype wire

@@ verif/penalty_contact_force_jacobian_unit_tb.sv @@
// Testbench for the penalty contact force and Jacobian unit: directed and random checks.
`default_nettype none

module penalty_contact_force_jacobian_unit_tb
	import pcfj_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int W = 32;
	localparam int F = 16;
	localparam int LATENCY = W + 72;

	// index with no register behind it
	localparam logic [IDX_W-1:0] REG_UNKNOWN = 2'd3;

	typedef struct {
		logic                active;
		logic signed [W-1:0] frc[3];
		logic signed [W-1:0] jac[6];   // xx yy zz xy xz yz
	} contact_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic signed [W-1:0] sep_x, sep_y, sep_z;
	logic                out_valid;
	logic                out_ready;
	logic                active;
	logic signed [W-1:0] force_x, force_y, force_z;
	logic signed [W-1:0] jac_xx, jac_yy, jac_zz, jac_xy, jac_xz, jac_yz;

	penalty_contact_force_jacobian_unit #(.WORD_WIDTH(W), .FRAC_BITS(F)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.sep_x(sep_x), .sep_y(sep_y), .sep_z(sep_z),
		.out_valid(out_valid), .out_ready(out_ready), .active(active),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.jac_xx(jac_xx), .jac_yy(jac_yy), .jac_zz(jac_zz),
		.jac_xy(jac_xy), .jac_xz(jac_xz), .jac_yz(jac_yz)
	);

	// shadow copy of the configuration registers
	logic [1:0]  dim_q;
	logic [63:0] act_q;
	logic [63:0] pen_q;

	contact_t contact_q[$];
	int       mismatches;
	bit       idle_en;
	int       out_stall;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] clamp_mag(logic [127:0] v);
		if (v > 128'h7FFF_FFFF_FFFF_FFFF)
			return 64'h7FFF_FFFF_FFFF_FFFF;
		return v[63:0];
	endfunction

	function automatic logic signed [W-1:0] sat_word(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[W-1:0];
	endfunction

	function automatic contact_t predict_contact(logic [W-1:0] sx, logic [W-1:0] sy,
			logic [W-1:0] sz);
		logic [W-1:0]  raw[3];
		logic [63:0]   mag[3];
		logic          ng[3];
		logic [63:0]   sumsq, d, gap, pg, pa, a, m, f;
		logic [127:0]  den3;
		contact_t      c;
		int            i, x, y;
		raw[0] = sx;
		raw[1] = sy;
		raw[2] = sz;
		c.active = 1'b0;
		for (i = 0; i < 3; i++)
			c.frc[i] = '0;
		for (i = 0; i < 6; i++)
			c.jac[i] = '0;
		sumsq = 0;
		for (i = 0; i < 3; i++) begin
			ng[i] = raw[i][W-1];
			mag[i] = ng[i] ? (64'd1 << W) - {32'd0, raw[i]} : {32'd0, raw[i]};
			if (i >= dim_q) begin
				mag[i] = 0;
				ng[i] = 1'b0;
			end
			sumsq = sumsq + mag[i] * mag[i];
		end
		d = isqrt(sumsq);
		if (d == 0)
			d = 1;
		if (d >= act_q)
			return c;
		c.active = 1'b1;
		gap = act_q - d;
		pg = pen_q * gap;
		pa = pen_q * act_q;
		for (i = 0; i < 3; i++) begin
			f = clamp_mag(({64'd0, pg} * {64'd0, mag[i]}) / ({64'd0, d} << F));
			c.frc[i] = sat_word(ng[i] ? -$signed(f) : $signed(f));
		end
		a = pg / d;
		den3 = {64'd0, d * d} * {64'd0, d};
		for (i = 0; i < 3; i++) begin
			if (i < dim_q) begin
				m = clamp_mag(({64'd0, pa} * {64'd0, mag[i] * mag[i]}) / den3);
				c.jac[i] = sat_word($signed(a) - $signed(m));
			end
		end
		for (i = 0; i < 3; i++) begin
			x = (i == 2) ? 1 : 0;
			y = (i == 0) ? 1 : 2;
			if (y < dim_q) begin
				m = clamp_mag(({64'd0, pa} * {64'd0, mag[x] * mag[y]}) / den3);
				c.jac[3+i] = sat_word((ng[x] != ng[y]) ? $signed(m) : -$signed(m));
			end
		end
		return c;
	endfunction

	task automatic idle_burst();
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic send_sep(logic [W-1:0] sx, logic [W-1:0] sy, logic [W-1:0] sz);
		idle_burst();
		in_valid <= 1'b1;
		sep_x <= sx;
		sep_y <= sy;
		sep_z <= sz;
		do
			@(posedge clk);
		while (!in_ready);
		contact_q.insert(contact_q.size(), predict_contact(sx, sy, sz));
	endtask

	// let the pipeline empty before touching the registers
	task automatic drain();
		in_valid <= 1'b0;
		while (contact_q.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 16) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DIMENSION: dim_q = val[1:0];
			REG_ACT_DIST:  act_q = {33'd0, val};
			REG_PENALTY:   pen_q = {33'd0, val};
			default: ;
		endcase
	endtask

	task automatic set_config(logic [1:0] dm, logic [CFG_W-1:0] ad, logic [CFG_W-1:0] pn);
		drain();
		write_reg(REG_DIMENSION, {29'd0, dm});
		write_reg(REG_ACT_DIST, ad);
		write_reg(REG_PENALTY, pn);
	endtask

	// random component: full-range or shifted down toward the activation radius
	function automatic logic [W-1:0] rand_comp();
		logic signed [W-1:0] v;
		v = $urandom;
		if ($urandom_range(0, 3) != 0)
			v = v >>> $urandom_range(8, 31);
		return v;
	endfunction

	always @(posedge clk) begin
		contact_t got, exp_c;
		bit       bad;
		int       i;
		if (out_valid && out_ready) begin
			got.active = active;
			got.frc[0] = force_x;
			got.frc[1] = force_y;
			got.frc[2] = force_z;
			got.jac[0] = jac_xx;
			got.jac[1] = jac_yy;
			got.jac[2] = jac_zz;
			got.jac[3] = jac_xy;
			got.jac[4] = jac_xz;
			got.jac[5] = jac_yz;
			if (contact_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat at %0t: got %p", $realtime, got);
			end else begin
				exp_c = contact_q.pop_front();
				bad = (got.active !== exp_c.active);
				for (i = 0; i < 3; i++)
					bad |= (got.frc[i] !== exp_c.frc[i]);
				for (i = 0; i < 6; i++)
					bad |= (got.jac[i] !== exp_c.jac[i]);
				if (bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at %0t: exp %p got %p", $realtime, exp_c, got);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b1;
			out_stall <= 0;
		end else if (out_stall > 0) begin
			out_stall <= out_stall - 1;
			out_ready <= (out_stall == 1);
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			out_stall <= $urandom_range(1, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_extremes();
		send_sep(32'h0, 32'h0, 32'h0);
		send_sep(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_sep(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_sep(32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
		send_sep(32'h0000_4000, 32'hFFFF_C000, 32'h0000_2000);
		send_sep(32'hFFFF_8000, 32'h0, 32'h0);
	endtask

	task automatic test_reset_config();
		send_extremes();
	endtask

	task automatic test_dimensions();
		set_config(2'd1, 31'd65536, 31'd131072);
		send_extremes();
		set_config(2'd2, 31'd65536, 31'd65536);
		send_extremes();
		// no component used: distance floors to one LSB
		set_config(2'd0, 31'd2, 31'd65536);
		send_sep(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
	endtask

	task automatic test_config_extremes();
		set_config(2'd3, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		send_extremes();
		set_config(2'd3, 31'd1, 31'd1);
		send_sep(32'h0, 32'h0, 32'h0);
		// unknown register index must leave everything alone
		drain();
		write_reg(REG_UNKNOWN, 31'h7FFF_FFFF);
		send_sep(32'h0, 32'h0, 32'h1);
	endtask

	task automatic test_random();
		int ph, k;
		for (ph = 0; ph < 11; ph++) begin
			if (ph == 10)
				idle_en = 1'b0;
			set_config(2'($urandom_range(0, 3)),
				CFG_W'(($urandom >> 1) >> $urandom_range(0, 20)),
				CFG_W'(($urandom >> 1) >> $urandom_range(0, 24)));
			if (act_q == 0)
				write_reg(REG_ACT_DIST, 31'd65536);
			if (pen_q == 0)
				write_reg(REG_PENALTY, 31'd1);
			for (k = 0; k < 50; k++)
				send_sep(rand_comp(), rand_comp(), rand_comp());
		end
	endtask

	initial begin
		#2_000_000;
		$display("penalty_contact_force_jacobian_unit regression: fail");
		$finish;
	end

	initial begin
		mismatches = 0;
		idle_en = 1'b1;
		dim_q = DIM_RESET;
		act_q = {33'd0, ACT_RESET};
		pen_q = {33'd0, PEN_RESET};
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sep_x = '0;
		sep_y = '0;
		sep_z = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_dimensions();
		test_config_extremes();
		test_random();
		drain();
		if (mismatches == 0)
			$display("penalty_contact_force_jacobian_unit regression: pass");
		else
			$display("penalty_contact_force_jacobian_unit regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/pcfj_pkg.sv
hdl/pcfj_dly.sv
hdl/pcfj_mul.sv
hdl/pcfj_sqrt.sv
hdl/pcfj_div.sv
hdl/penalty_contact_force_jacobian_unit.sv
verif/penalty_contact_force_jacobian_unit_tb.sv
